// File: rtl/rpdf_pkg.sv
// rpdf_pkg: shared constants for the radio packet duplicate filter
// packet geometry, register reset values, register indexes and verdict codes
// no dependencies
`timescale 1ns / 1ps

package rpdf_pkg;

   // packet geometry
   localparam int PACKET_BYTES     = 32;
   localparam int PACKET_BITS      = PACKET_BYTES * 8;
   localparam int LENGTH_OVERHEAD  = 4;
   localparam int SPAN_W           = 9;
   localparam int HISTORY_DEPTH    = 8;

   // configuration registers
   localparam int           CSR_ADDR_W         = 3;
   localparam int           CSR_DATA_W         = 32;
   localparam logic         CSR_IDX_HEADER     = 1'b0;
   localparam logic         CSR_IDX_MAX_LENGTH = 1'b1;
   localparam logic [7:0]   HEADER_RESET       = 8'hC0;
   localparam logic [4:0]   MAX_LENGTH_RESET   = 5'd28;

   // verdict codes
   localparam logic [1:0] VERDICT_NOISE     = 2'd0;
   localparam logic [1:0] VERDICT_INVALID   = 2'd1;
   localparam logic [1:0] VERDICT_DUPLICATE = 2'd2;
   localparam logic [1:0] VERDICT_ACCEPTED  = 2'd3;

   // result item width: verdict, evicted, stored_count, padded to a byte
   localparam int RSP_FIELDS_W = 7;
   localparam int RSP_DATA_W   = 8;

endpackage

// File: rtl/radio_packet_dedup_filter.sv
// radio_packet_dedup_filter: top level of the radio packet duplicate filter
// holds the history memory, its scan sequencer and the apb register file
// depends on rpdf_pkg
`timescale 1ns / 1ps

// Each input item is one 32-byte radio packet (four 64-bit words in req_tdata,
// byte 0 in bits 7:0) plus the upstream crc pass flag in req_tuser. A packet is
// sane when byte 0 equals the header register and byte 1 (length) is at most
// the length register; it is checked against every held history entry over
// bytes 0 to length+3 (capped at the packet end). Valid new packets go into a
// ring of HISTORY_DEPTH entries, evicting the oldest when full. One result item
// comes back per packet: verdict, evicted flag and the number of held entries.
// The history sits in a single memory with one read port, read one entry per
// cycle, so a packet holds the block through a scan of every held entry and a
// done state before the next one is accepted, and longer while the previous
// result still waits untaken. A finished result waits in an output register,
// so the next packet can be accepted while it is not yet taken. The history
// needs no clearing after reset: only entries below the fill count are ever
// read. Registers are on a 32-bit apb port: header value at byte address 0,
// max length at 4.
module radio_packet_dedup_filter #(
   parameter int HISTORY_DEPTH = rpdf_pkg::HISTORY_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // packet_word0 [63:0], packet_word1 [127:64], packet_word2 [191:128],
   // packet_word3 [255:192]
   input  logic [rpdf_pkg::PACKET_BITS-1:0]   req_tdata,
   // crc_ok [0]
   input  logic                               req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // verdict [1:0], evicted [2], stored_count [6:3], zero [7]
   output logic [rpdf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rpdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rpdf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rpdf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int PB     = rpdf_pkg::PACKET_BITS;

   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(HISTORY_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W:0]    DEPTH_SUM  = (CNT_W + 1)'(HISTORY_DEPTH);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [7:0] header_ff, header_in;
   logic [4:0] max_len_ff, max_len_in;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      header_in  = header_ff;
      max_len_in = max_len_ff;
      if (csr_write) begin
         // register index is the word address; byte offset bits are ignored
         case (csr_paddr[2])
            rpdf_pkg::CSR_IDX_HEADER:     header_in  = csr_pwdata[7:0];
            rpdf_pkg::CSR_IDX_MAX_LENGTH: max_len_in = csr_pwdata[4:0];
            default: begin
               header_in  = header_ff;
               max_len_in = max_len_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rpdf_pkg::CSR_IDX_HEADER:     csr_prdata = {24'd0, header_ff};
         rpdf_pkg::CSR_IDX_MAX_LENGTH: csr_prdata = {27'd0, max_len_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= rpdf_pkg::HEADER_RESET;
         max_len_ff <= rpdf_pkg::MAX_LENGTH_RESET;
      end else begin
         header_ff  <= header_in;
         max_len_ff <= max_len_in;
      end
   end

   // ---------------------------------------------------------------------
   // packet capture and scan sequencer
   // ---------------------------------------------------------------------
   logic [1:0]        state_ff, state_in;
   logic [PB-1:0]     pkt_ff, pkt_in;
   logic [PB-1:0]     mask_ff, mask_in;
   logic              sane_ff, sane_in;
   logic              crc_ff, crc_in;
   logic              hit_ff, hit_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]  issued_ff, issued_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [rpdf_pkg::RSP_FIELDS_W-1:0] rsp_fields_ff, rsp_fields_in;

   logic                      req_take;
   logic                      rsp_free;
   logic                      entry_match;
   logic [7:0]                req_len;
   logic [rpdf_pkg::SPAN_W-1:0] req_span;
   logic [CNT_W:0]            fill_sum;
   logic [SLOT_W-1:0]         fill_slot;
   logic [1:0]                verdict;
   logic                      evict;
   logic [CNT_W+3:0]          count_wide;

   // ---------------------------------------------------------------------
   // history memory: one entry per packet, one read and one write port
   // ---------------------------------------------------------------------
   logic [PB-1:0]     hist_mem [HISTORY_DEPTH];
   logic [PB-1:0]     rd_data_ff;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= pkt_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // compare span: length byte plus header overhead, capped at the packet end
   assign req_len = req_tdata[15:8];
   always_comb begin
      req_span = rpdf_pkg::SPAN_W'(req_len) + rpdf_pkg::SPAN_W'(rpdf_pkg::LENGTH_OVERHEAD);
      if (req_span > rpdf_pkg::SPAN_W'(rpdf_pkg::PACKET_BYTES)) begin
         req_span = rpdf_pkg::SPAN_W'(rpdf_pkg::PACKET_BYTES);
      end
      for (int b = 0; b < rpdf_pkg::PACKET_BYTES; b++) begin
         mask_in[b*8 +: 8] = {8{rpdf_pkg::SPAN_W'(b) < req_span}};
      end
   end

   // masked compare of the entry read in the previous cycle
   assign entry_match = ~|((rd_data_ff ^ pkt_ff) & mask_ff);

   // next free slot when the ring is not full
   always_comb begin
      fill_sum = {1'b0, CNT_W'(oldest_ff)} + {1'b0, count_ff};
      if (fill_sum >= DEPTH_SUM) begin
         fill_sum = fill_sum - DEPTH_SUM;
      end
      fill_slot = fill_sum[SLOT_W-1:0];
   end

   // verdict from the registered checks and the scan result
   always_comb begin
      if (!sane_ff) begin
         verdict = rpdf_pkg::VERDICT_NOISE;
      end else if (!crc_ff) begin
         verdict = hit_ff ? rpdf_pkg::VERDICT_NOISE : rpdf_pkg::VERDICT_INVALID;
      end else if (hit_ff) begin
         verdict = rpdf_pkg::VERDICT_DUPLICATE;
      end else begin
         verdict = rpdf_pkg::VERDICT_ACCEPTED;
      end
   end

   assign evict = (verdict == rpdf_pkg::VERDICT_ACCEPTED) && (count_ff == DEPTH_CNT);

   always_comb begin
      state_in      = state_ff;
      pkt_in        = pkt_ff;
      sane_in       = sane_ff;
      crc_in        = crc_ff;
      hit_in        = hit_ff;
      rd_pend_in    = 1'b0;
      issued_in     = issued_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      oldest_in     = oldest_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_fields_in = rsp_fields_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_slot;
      count_wide    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pkt_in    = req_tdata;
               sane_in   = (req_tdata[7:0] == header_ff) && (req_len <= {3'd0, max_len_ff});
               crc_in    = req_tuser;
               hit_in    = 1'b0;
               issued_in = '0;
               ptr_in    = oldest_ff;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // fold in the compare of the entry read last cycle
            hit_in = hit_ff | (rd_pend_ff & entry_match);
            if (issued_ff == count_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               issued_in  = issued_ff + 1'b1;
               ptr_in     = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               if (verdict == rpdf_pkg::VERDICT_ACCEPTED) begin
                  wr_en = 1'b1;
                  if (evict) begin
                     // overwrite the oldest entry and age the ring by one
                     wr_addr   = oldest_ff;
                     oldest_in = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               count_wide    = {4'd0, count_in};
               rsp_fields_in = {count_wide[3:0], evict, verdict};
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         count_ff     <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan bookkeeping, no reset needed
   always_ff @(posedge clock) begin
      pkt_ff        <= pkt_in;
      sane_ff       <= sane_in;
      crc_ff        <= crc_in;
      hit_ff        <= hit_in;
      issued_ff     <= issued_in;
      ptr_ff        <= ptr_in;
      rsp_fields_ff <= rsp_fields_in;
      if (req_take) begin
         mask_ff <= mask_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_fields_ff};

endmodule

// File: rtl/rpdf_checker.sv
// rpdf_checker: port-level assertions for the radio packet duplicate filter
// bound to radio_packet_dedup_filter; depends on rpdf_pkg
`timescale 1ns / 1ps

module rpdf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rpdf_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // one packet at a time: the cycle after a take the block is busy scanning
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block ready again right after taking a packet");

   // an eviction only happens when a new packet is stored
   a_evict_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> (rsp_tdata[1:0] == rpdf_pkg::VERDICT_ACCEPTED))
      else $error("eviction reported without an accepted packet");

   // no result is shown right after reset
   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result dropped or changed");

endmodule

bind radio_packet_dedup_filter rpdf_checker u_rpdf_checker (.*);
